// ----- sv/jls_pkg.sv -----
// ----------------------------------------------------------------------------
// jls_pkg
// Shared types, codes and constants of the Jacobi linear solver.
// ----------------------------------------------------------------------------
`default_nettype none

package jls_pkg;

   localparam int DEF_MAX_UNKNOWNS = 16;

   localparam int VALUE_W     = 32;
   localparam int IDX_W       = 6;
   localparam int SWEEP_W     = 16;
   localparam int SIZE_W      = 7;
   localparam int TOL_W       = 31;
   localparam int CSR_W       = 31;
   localparam int CSR_IDX_W   = 2;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 56;

   localparam logic [SIZE_W-1:0]  RST_SIZE_IN_USE    = 7'd16;
   localparam logic [TOL_W-1:0]   RST_TOLERANCE      = 31'd66;
   localparam logic [SWEEP_W-1:0] RST_MAX_ITERATIONS = 16'd1000;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_COEF  = 2'd0,
      OP_LOAD_RHS   = 2'd1,
      OP_LOAD_GUESS = 2'd2,
      OP_SOLVE      = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      RES_CONVERGED = 2'd0,
      RES_LIMIT     = 2'd1,
      RES_REJECTED  = 2'd2
   } result_status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIZE_IN_USE    = 2'd0,
      CSR_TOLERANCE      = 2'd1,
      CSR_MAX_ITERATIONS = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DOM_ROW,
      S_DOM_RD,
      S_DOM_ACC,
      S_DOM_CHK,
      S_REJ,
      S_SW_CHK,
      S_ROW_BEGIN,
      S_ROW_CAP,
      S_TERM_RD,
      S_TERM_MUL,
      S_TERM_TRN,
      S_TERM_ACC,
      S_NUM,
      S_DIV_START,
      S_DIV_WAIT,
      S_RES,
      S_CHG,
      S_OUT_RD,
      S_OUT_LOAD,
      S_OUT_WAIT
   } fsm_type;

   typedef struct packed {
      logic load_we;
      logic start_solve;
      logic dom_row;
      logic dom_acc;
      logic dom_next;
      logic sw_begin;
      logic row_begin;
      logic row_cap;
      logic term_rd;
      logic term_mul;
      logic term_trn;
      logic term_acc;
      logic num_calc;
      logic div_start;
      logic res_calc;
      logic chg;
      logic out_begin;
      logic out_load;
      logic out_rej;
      logic out_adv;
   } cmd_type;

   typedef struct packed {
      logic i_last;
      logic j_last;
      logic dom_fail;
      logic keep_going;
      logic div_done;
      logic out_last;
   } stat_type;

endpackage

`default_nettype wire

// ----- sv/jls_div.sv -----
// ----------------------------------------------------------------------------
// jls_div
// Restoring divider, one quotient bit per cycle, with overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module jls_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [62:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [30:0]      quotient,
   output logic             overflow
);

   localparam int QW  = 31;
   localparam int CNW = $clog2(QW + 1);

   logic           busy_ff;
   logic           done_ff;
   logic [CNW-1:0] cnt_ff;
   logic [31:0]    rem_ff;
   logic [QW-1:0]  lo_ff;
   logic [QW-1:0]  q_ff;
   logic [31:0]    d_ff;
   logic           ovf_ff;

   logic [32:0]    trial_in;
   logic           ge_in;
   logic [32:0]    diff_in;

   always_comb begin
      trial_in = {rem_ff, lo_ff[QW-1]};
      ge_in    = trial_in >= {1'b0, d_ff};
      diff_in  = trial_in - {1'b0, d_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNW'(QW);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[62:31];
         lo_ff  <= dividend[30:0];
         d_ff   <= divisor;
         ovf_ff <= dividend[62:31] >= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge_in ? diff_in[31:0] : trial_in[31:0];
         lo_ff  <= {lo_ff[QW-2:0], 1'b0};
         q_ff   <= {q_ff[QW-2:0], ge_in};
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;
   assign overflow = ovf_ff;

endmodule

`default_nettype wire

// ----- sv/jls_dpath.sv -----
// ----------------------------------------------------------------------------
// jls_dpath
// Solver datapath: stores, counters, multiplier, accumulators and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module jls_dpath #(
   parameter int MAX_UNKNOWNS = jls_pkg::DEF_MAX_UNKNOWNS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [jls_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [jls_pkg::CSR_W-1:0]      csr_wdata,
   input  wire logic [jls_pkg::OP_W-1:0]       req_opcode,
   input  wire logic [jls_pkg::IDX_W-1:0]      req_row,
   input  wire logic [jls_pkg::IDX_W-1:0]      req_col,
   input  wire logic [jls_pkg::VALUE_W-1:0]    req_value,
   input  wire jls_pkg::cmd_type               cmd,
   output jls_pkg::stat_type                   stat,
   output logic [jls_pkg::IDX_W-1:0]           rsp_index,
   output logic [jls_pkg::VALUE_W-1:0]         rsp_solution,
   output logic [jls_pkg::STATUS_W-1:0]        rsp_status,
   output logic [jls_pkg::SWEEP_W-1:0]         rsp_sweeps,
   output logic                                rsp_last
);

   localparam int IW     = $clog2(MAX_UNKNOWNS);
   localparam int CDEPTH = MAX_UNKNOWNS * MAX_UNKNOWNS;
   localparam int CAW    = $clog2(CDEPTH);
   localparam int VDEPTH = 2 * MAX_UNKNOWNS;
   localparam int VAW    = $clog2(VDEPTH);
   localparam int DSUM_W = 32 + IW;
   localparam int TERM_W = 48;
   localparam int ACC_W  = TERM_W + IW;
   localparam int NUM_W  = ACC_W + 1;
   localparam int NMAG_W = 47;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   function automatic logic [CAW-1:0] caddr(input logic [IW-1:0] r, input logic [IW-1:0] c);
      return CAW'(int'(r) * MAX_UNKNOWNS + int'(c));
   endfunction

   function automatic logic [VAW-1:0] vaddr(input logic b, input logic [IW-1:0] idx);
      return VAW'(int'(b) * MAX_UNKNOWNS + int'(idx));
   endfunction

   // configuration registers
   logic [jls_pkg::SIZE_W-1:0]  size_ff;
   logic [jls_pkg::TOL_W-1:0]   tol_ff;
   logic [jls_pkg::SWEEP_W-1:0] maxit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= jls_pkg::RST_SIZE_IN_USE;
         tol_ff   <= jls_pkg::RST_TOLERANCE;
         maxit_ff <= jls_pkg::RST_MAX_ITERATIONS;
      end else if (csr_we) begin
         case (jls_pkg::csr_index_type'(csr_index))
            jls_pkg::CSR_SIZE_IN_USE: begin
               size_ff <= csr_wdata[jls_pkg::SIZE_W-1:0];
            end
            jls_pkg::CSR_TOLERANCE: begin
               tol_ff <= csr_wdata[jls_pkg::TOL_W-1:0];
            end
            jls_pkg::CSR_MAX_ITERATIONS: begin
               maxit_ff <= csr_wdata[jls_pkg::SWEEP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // last index in use, size clamped to 1..MAX_UNKNOWNS
   logic [IW-1:0]           n_m1;
   logic [MAX_UNKNOWNS-1:0] live_mask;

   always_comb begin
      if (size_ff == '0) begin
         n_m1 = '0;
      end else if (size_ff > jls_pkg::SIZE_W'(MAX_UNKNOWNS)) begin
         n_m1 = IW'(MAX_UNKNOWNS - 1);
      end else begin
         n_m1 = IW'(size_ff - 1'b1);
      end
      // elements that take part in the current solve
      for (int k = 0; k < MAX_UNKNOWNS; k++) begin
         live_mask[k] = IW'(k) <= n_m1;
      end
   end

   // control registers
   logic [IW-1:0]               i_ff;
   logic [IW-1:0]               j_ff;
   logic [MAX_UNKNOWNS-1:0]     sel_ff;
   logic [31:0]                 diff_ff;
   logic [jls_pkg::SWEEP_W-1:0] sweep_ff;

   // payload registers
   logic [DSUM_W-1:0]         dsum_ff;
   logic [31:0]               diag_ff;
   logic [31:0]               prev_ff;
   logic [31:0]               b_ff;
   logic [31:0]               amag_ff;
   logic                      a_neg_ff;
   logic signed [63:0]        prod_ff;
   logic [TERM_W-1:0]         term_ff;
   logic [ACC_W-1:0]          acc_ff;
   logic [NUM_W-1:0]          num_ff;
   logic                      neg_ff;
   logic [31:0]               res_ff;

   // stores, each vector element lives in the bank its select bit points at
   logic [31:0] coef_mem [0:CDEPTH-1];
   logic [31:0] rhs_mem  [0:MAX_UNKNOWNS-1];
   logic [31:0] vec_mem  [0:VDEPTH-1];
   logic [31:0] coef_rd_ff;
   logic [31:0] rhs_rd_ff;
   logic [31:0] vec_rd_ff;

   logic              row_ok;
   logic              col_ok;
   logic              coef_we;
   logic              rhs_we;
   logic              vec_we;
   logic [CAW-1:0]    coef_waddr;
   logic [CAW-1:0]    coef_raddr;
   logic [IW-1:0]     vec_ridx;
   logic [VAW-1:0]    vec_waddr;
   logic [VAW-1:0]    vec_raddr;
   logic [31:0]       vec_wdata;

   always_comb begin
      row_ok     = {1'b0, req_row} < 7'(MAX_UNKNOWNS);
      col_ok     = {1'b0, req_col} < 7'(MAX_UNKNOWNS);
      coef_we    = cmd.load_we && row_ok && col_ok &&
                   (req_opcode == jls_pkg::OP_LOAD_COEF);
      rhs_we     = cmd.load_we && row_ok && (req_opcode == jls_pkg::OP_LOAD_RHS);
      coef_waddr = caddr(req_row[IW-1:0], req_col[IW-1:0]);
      coef_raddr = caddr(i_ff, cmd.row_begin ? i_ff : j_ff);
      vec_ridx   = cmd.term_rd ? j_ff : i_ff;
      vec_raddr  = vaddr(sel_ff[vec_ridx], vec_ridx);
      if (cmd.chg) begin
         vec_we    = 1'b1;
         vec_waddr = vaddr(~sel_ff[i_ff], i_ff);
         vec_wdata = res_ff;
      end else begin
         vec_we    = cmd.load_we && row_ok && (req_opcode == jls_pkg::OP_LOAD_GUESS);
         vec_waddr = vaddr(sel_ff[req_row[IW-1:0]], req_row[IW-1:0]);
         vec_wdata = req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= req_value;
      end
      coef_rd_ff <= coef_mem[coef_raddr];
   end

   always_ff @(posedge clock) begin
      if (rhs_we) begin
         rhs_mem[req_row[IW-1:0]] <= req_value;
      end
      rhs_rd_ff <= rhs_mem[i_ff];
   end

   always_ff @(posedge clock) begin
      if (vec_we) begin
         vec_mem[vec_waddr] <= vec_wdata;
      end
      vec_rd_ff <= vec_mem[vec_raddr];
   end

   // arithmetic
   logic [31:0]        coef_mag;
   logic [63:0]        pmag;
   logic [TERM_W-1:0]  pshift;
   logic [TERM_W-1:0]  term_in;
   logic [NUM_W-1:0]   nmag;
   logic [NMAG_W-1:0]  nclamp;
   logic [62:0]        dividend;
   logic               div_done;
   logic [30:0]        quot;
   logic               quot_ovf;
   logic [31:0]        res_in;
   logic [32:0]        delta;
   logic [31:0]        chg_in;

   always_comb begin
      coef_mag = mag32(coef_rd_ff);
      pmag     = prod_ff[63] ? (~prod_ff + 64'd1) : prod_ff;
      pshift   = pmag[63:16];
      term_in  = prod_ff[63] ? (~pshift + 1'b1) : pshift;
      nmag     = num_ff[NUM_W-1] ? (~num_ff + 1'b1) : num_ff;
      // numerator magnitude capped at 2^46, every quotient above saturates
      if (nmag > NUM_W'(64'd1 << 46)) begin
         nclamp = NMAG_W'(64'd1 << 46);
      end else begin
         nclamp = nmag[NMAG_W-1:0];
      end
      dividend = {nclamp, 16'd0};
      if (quot_ovf) begin
         res_in = neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         res_in = neg_ff ? (~{1'b0, quot} + 32'd1) : {1'b0, quot};
      end
      delta  = {res_ff[31], res_ff} - {prev_ff[31], prev_ff};
      chg_in = delta[32] ? 32'(~delta + 33'd1) : delta[31:0];
   end

   jls_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (amag_ff),
      .done     (div_done),
      .quotient (quot),
      .overflow (quot_ovf)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff     <= '0;
         j_ff     <= '0;
         sel_ff   <= '0;
         diff_ff  <= '0;
         sweep_ff <= '0;
      end else begin
         if (cmd.start_solve) begin
            i_ff     <= '0;
            diff_ff  <= {1'b0, tol_ff};
            sweep_ff <= '0;
         end
         if (cmd.dom_row || cmd.row_begin) begin
            j_ff <= '0;
         end
         if (cmd.dom_acc || cmd.term_acc) begin
            j_ff <= j_ff + 1'b1;
         end
         if (cmd.dom_next || cmd.out_adv) begin
            i_ff <= i_ff + 1'b1;
         end
         if (cmd.sw_begin) begin
            i_ff    <= '0;
            diff_ff <= '0;
         end
         if (cmd.out_begin) begin
            i_ff <= '0;
         end
         if (cmd.chg) begin
            if (chg_in > diff_ff) begin
               diff_ff <= chg_in;
            end
            if (i_ff == n_m1) begin
               sweep_ff <= sweep_ff + 1'b1;
               // new values become current, elements out of use stay put
               sel_ff   <= sel_ff ^ live_mask;
            end else begin
               i_ff <= i_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.dom_row) begin
         dsum_ff <= '0;
      end
      if (cmd.dom_acc) begin
         if (j_ff == i_ff) begin
            diag_ff <= coef_mag;
         end else begin
            dsum_ff <= dsum_ff + DSUM_W'(coef_mag);
         end
      end
      if (cmd.row_begin) begin
         acc_ff <= '0;
      end
      if (cmd.row_cap) begin
         prev_ff  <= vec_rd_ff;
         b_ff     <= rhs_rd_ff;
         amag_ff  <= coef_mag;
         a_neg_ff <= coef_rd_ff[31];
      end
      if (cmd.term_mul) begin
         prod_ff <= $signed(coef_rd_ff) * $signed(vec_rd_ff);
      end
      if (cmd.term_trn) begin
         term_ff <= term_in;
      end
      if (cmd.term_acc && (j_ff != i_ff)) begin
         acc_ff <= acc_ff + {{(ACC_W-TERM_W){term_ff[TERM_W-1]}}, term_ff};
      end
      if (cmd.num_calc) begin
         num_ff <= {{(NUM_W-32){b_ff[31]}}, b_ff} - {acc_ff[ACC_W-1], acc_ff};
      end
      if (cmd.div_start) begin
         neg_ff <= num_ff[NUM_W-1] ^ a_neg_ff;
      end
      if (cmd.res_calc) begin
         res_ff <= res_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_rej) begin
         rsp_index    <= '0;
         rsp_solution <= '0;
         rsp_status   <= jls_pkg::RES_REJECTED;
         rsp_sweeps   <= '0;
         rsp_last     <= 1'b1;
      end else if (cmd.out_load) begin
         rsp_index    <= jls_pkg::IDX_W'(i_ff);
         rsp_solution <= vec_rd_ff;
         rsp_status   <= (diff_ff < {1'b0, tol_ff}) ? jls_pkg::RES_CONVERGED
                                                    : jls_pkg::RES_LIMIT;
         rsp_sweeps   <= sweep_ff;
         rsp_last     <= (i_ff == n_m1);
      end
   end

   always_comb begin
      stat.i_last     = (i_ff == n_m1);
      stat.j_last     = (j_ff == n_m1);
      stat.dom_fail   = DSUM_W'(diag_ff) <= dsum_ff;
      stat.keep_going = (diff_ff >= {1'b0, tol_ff}) && (sweep_ff < maxit_ff);
      stat.div_done   = div_done;
      stat.out_last   = rsp_last;
   end

endmodule

`default_nettype wire

// ----- sv/jls_ctrl.sv -----
// ----------------------------------------------------------------------------
// jls_ctrl
// Solver sequencer: load, dominance check, sweeps and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module jls_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   input  wire logic [jls_pkg::OP_W-1:0] req_opcode,
   input  wire logic                     rsp_tready,
   input  wire jls_pkg::stat_type        stat,
   output logic                          req_tready,
   output logic                          rsp_tvalid,
   output jls_pkg::cmd_type              cmd
);

   jls_pkg::fsm_type state_ff;
   jls_pkg::fsm_type state_in;
   logic             req_take;
   logic             is_solve;

   always_comb begin
      req_take = req_tvalid && (state_ff == jls_pkg::S_IDLE);
      is_solve = req_opcode == jls_pkg::OP_SOLVE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jls_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         jls_pkg::S_IDLE: begin
            if (req_take && is_solve) begin
               state_in = jls_pkg::S_DOM_ROW;
            end
         end
         jls_pkg::S_DOM_ROW: begin
            state_in = jls_pkg::S_DOM_RD;
         end
         jls_pkg::S_DOM_RD: begin
            state_in = jls_pkg::S_DOM_ACC;
         end
         jls_pkg::S_DOM_ACC: begin
            state_in = stat.j_last ? jls_pkg::S_DOM_CHK : jls_pkg::S_DOM_RD;
         end
         jls_pkg::S_DOM_CHK: begin
            if (stat.dom_fail) begin
               state_in = jls_pkg::S_REJ;
            end else if (stat.i_last) begin
               state_in = jls_pkg::S_SW_CHK;
            end else begin
               state_in = jls_pkg::S_DOM_ROW;
            end
         end
         jls_pkg::S_REJ: begin
            state_in = jls_pkg::S_OUT_WAIT;
         end
         jls_pkg::S_SW_CHK: begin
            state_in = stat.keep_going ? jls_pkg::S_ROW_BEGIN : jls_pkg::S_OUT_RD;
         end
         jls_pkg::S_ROW_BEGIN: begin
            state_in = jls_pkg::S_ROW_CAP;
         end
         jls_pkg::S_ROW_CAP: begin
            state_in = jls_pkg::S_TERM_RD;
         end
         jls_pkg::S_TERM_RD: begin
            state_in = jls_pkg::S_TERM_MUL;
         end
         jls_pkg::S_TERM_MUL: begin
            state_in = jls_pkg::S_TERM_TRN;
         end
         jls_pkg::S_TERM_TRN: begin
            state_in = jls_pkg::S_TERM_ACC;
         end
         jls_pkg::S_TERM_ACC: begin
            state_in = stat.j_last ? jls_pkg::S_NUM : jls_pkg::S_TERM_RD;
         end
         jls_pkg::S_NUM: begin
            state_in = jls_pkg::S_DIV_START;
         end
         jls_pkg::S_DIV_START: begin
            state_in = jls_pkg::S_DIV_WAIT;
         end
         jls_pkg::S_DIV_WAIT: begin
            if (stat.div_done) begin
               state_in = jls_pkg::S_RES;
            end
         end
         jls_pkg::S_RES: begin
            state_in = jls_pkg::S_CHG;
         end
         jls_pkg::S_CHG: begin
            state_in = stat.i_last ? jls_pkg::S_SW_CHK : jls_pkg::S_ROW_BEGIN;
         end
         jls_pkg::S_OUT_RD: begin
            state_in = jls_pkg::S_OUT_LOAD;
         end
         jls_pkg::S_OUT_LOAD: begin
            state_in = jls_pkg::S_OUT_WAIT;
         end
         jls_pkg::S_OUT_WAIT: begin
            if (rsp_tready) begin
               state_in = stat.out_last ? jls_pkg::S_IDLE : jls_pkg::S_OUT_RD;
            end
         end
         default: begin
            state_in = jls_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         jls_pkg::S_IDLE: begin
            req_tready      = 1'b1;
            cmd.load_we     = req_take && !is_solve;
            cmd.start_solve = req_take && is_solve;
         end
         jls_pkg::S_DOM_ROW: begin
            cmd.dom_row = 1'b1;
         end
         jls_pkg::S_DOM_ACC: begin
            cmd.dom_acc = 1'b1;
         end
         jls_pkg::S_DOM_CHK: begin
            cmd.dom_next = !stat.dom_fail && !stat.i_last;
         end
         jls_pkg::S_REJ: begin
            cmd.out_rej = 1'b1;
         end
         jls_pkg::S_SW_CHK: begin
            cmd.sw_begin  = stat.keep_going;
            cmd.out_begin = !stat.keep_going;
         end
         jls_pkg::S_ROW_BEGIN: begin
            cmd.row_begin = 1'b1;
         end
         jls_pkg::S_ROW_CAP: begin
            cmd.row_cap = 1'b1;
         end
         jls_pkg::S_TERM_RD: begin
            cmd.term_rd = 1'b1;
         end
         jls_pkg::S_TERM_MUL: begin
            cmd.term_mul = 1'b1;
         end
         jls_pkg::S_TERM_TRN: begin
            cmd.term_trn = 1'b1;
         end
         jls_pkg::S_TERM_ACC: begin
            cmd.term_acc = 1'b1;
         end
         jls_pkg::S_NUM: begin
            cmd.num_calc = 1'b1;
         end
         jls_pkg::S_DIV_START: begin
            cmd.div_start = 1'b1;
         end
         jls_pkg::S_RES: begin
            cmd.res_calc = 1'b1;
         end
         jls_pkg::S_CHG: begin
            cmd.chg = 1'b1;
         end
         jls_pkg::S_OUT_LOAD: begin
            cmd.out_load = 1'b1;
         end
         jls_pkg::S_OUT_WAIT: begin
            rsp_tvalid  = 1'b1;
            cmd.out_adv = rsp_tready && !stat.out_last;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- sv/jacobi_linear_solver.sv -----
// ----------------------------------------------------------------------------
// jacobi_linear_solver
// Jacobi iterative solver for a dense system A x = b in signed Q16.16.
// ----------------------------------------------------------------------------
// sequence: a load transaction is taken in the idle state; a solve runs the
//   dominance check, then sweeps until converged or at the iteration limit,
//   then leaves the sweep loop and emits its results, each held until taken
// throughput: one transaction at a time; each row of a sweep is set by the
//   multiply-accumulate per term and the 31-step serial divider
// reset: synchronous, registers return to size 16, tolerance 66, limit 1000;
//   stores are not cleared
`default_nettype none

module jacobi_linear_solver #(
   parameter int MAX_UNKNOWNS = jls_pkg::DEF_MAX_UNKNOWNS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // configuration write port
   input  wire logic                              csr_we,
   input  wire logic [jls_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [jls_pkg::CSR_W-1:0]         csr_wdata,
   // request stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // row[5:0], col[11:6], value[43:12], zero fill above
   input  wire logic [jls_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // opcode[1:0]
   input  wire logic [jls_pkg::OP_W-1:0]          req_tuser,
   // response stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // index[5:0], solution[37:6], sweeps_done[53:38], zero fill above
   output logic [jls_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   // status[1:0]
   output logic [jls_pkg::STATUS_W-1:0]           rsp_tuser,
   output logic                                   rsp_tlast
);

   jls_pkg::cmd_type  cmd;
   jls_pkg::stat_type stat;

   logic [jls_pkg::IDX_W-1:0]   rsp_index;
   logic [jls_pkg::VALUE_W-1:0] rsp_solution;
   logic [jls_pkg::SWEEP_W-1:0] rsp_sweeps;

   // sequencer: owns both handshakes, issues at most one command per cycle
   jls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_opcode (req_tuser),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   // stores, arithmetic and result register
   jls_dpath #(
      .MAX_UNKNOWNS (MAX_UNKNOWNS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_opcode   (req_tuser),
      .req_row      (req_tdata[5:0]),
      .req_col      (req_tdata[11:6]),
      .req_value    (req_tdata[43:12]),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_index    (rsp_index),
      .rsp_solution (rsp_solution),
      .rsp_status   (rsp_tuser),
      .rsp_sweeps   (rsp_sweeps),
      .rsp_last     (rsp_tlast)
   );

   // response packing, lowest field first
   assign rsp_tdata = {2'b00, rsp_sweeps, rsp_solution, rsp_index};

   // the block never takes a request while a result transaction is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while result pending");

   // a rejection is a single closing transaction at index zero
   a_reject_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == jls_pkg::RES_REJECTED)) |->
      (rsp_tlast && (rsp_tdata[5:0] == 6'd0)))
      else $error("rejection not a single last result");

   // after the closing result the block is ready again
   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("not ready after final result");

   // the divider cannot finish the cycle after it was started
   a_div_latency: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !stat.div_done)
      else $error("divider finished too early");

endmodule

`default_nettype wire
